// ===== src/lfbd_pkg.sv =====
package lfbd_pkg;

  localparam int unsigned OUT_BYTES = 4;
  localparam logic [3:0] FLAG_ITEMS = 4'd8;

  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_ITEM  = 2'd1,
    PH_DHIGH = 2'd2,
    PH_LEN   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_END  = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch;       // capture the incoming byte
    logic flag;        // load a new flag byte
    logic lit;         // literal: write history and send it out
    logic dlow;        // token distance low byte
    logic dhigh;       // token distance high byte
    logic end_mark;    // end of stream result
    logic bad;         // bad distance result
    logic skip;        // zero length copy, item finished
    logic copy_start;  // set up source pointer and length
    logic rd;          // read one history byte
    logic wr;          // write the byte read back into history
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    phase_t phase;
    logic   flag_bit;
    logic   end_tok;
    logic   dist_bad;
    logic   len_zero;
    logic   out_free;
    logic   emit_due;
    logic   copy_last;
  } sts_t;

endpackage

// ===== src/lzss_flag_byte_decoder.sv =====
// lzss decoder for flag-byte streams: takes one compressed byte per transfer and
// returns decoded bytes packed up to four per result, with status for end of
// stream and bad distance. a literal waits while the output register holds a
// stalled result; a copy reads each byte from the history ram (registered
// read) and writes it back before the next read, so overlapping copies
// repeat. after a bad distance every input is taken and dropped until reset.
module lzss_flag_byte_decoder #(
  parameter int HISTORY_ADDR_BITS = 16,
  parameter int BYTES_PER_RESULT  = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte0,
  output logic [7:0] out_byte1,
  output logic [7:0] out_byte2,
  output logic [7:0] out_byte3,
  output logic [2:0] byte_count,
  output logic [1:0] status,
  output logic       last
);
  import lfbd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lfbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfbd_datapath #(
    .HISTORY_ADDR_BITS (HISTORY_ADDR_BITS),
    .BYTES_PER_RESULT  (BYTES_PER_RESULT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte0  (out_byte0),
    .out_byte1  (out_byte1),
    .out_byte2  (out_byte2),
    .out_byte3  (out_byte3),
    .byte_count (byte_count),
    .status     (status),
    .last       (last)
  );

endmodule

// ===== src/lfbd_ram.sv =====
module lfbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lfbd_datapath.sv =====
module lfbd_datapath #(
  parameter int HISTORY_ADDR_BITS = 16,
  parameter int BYTES_PER_RESULT  = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  lfbd_pkg::cmd_t cmd,
  output lfbd_pkg::sts_t sts,
  input  logic [7:0]    in_byte,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte0,
  output logic [7:0]    out_byte1,
  output logic [7:0]    out_byte2,
  output logic [7:0]    out_byte3,
  output logic [2:0]    byte_count,
  output logic [1:0]    status,
  output logic          last
);
  import lfbd_pkg::*;

  localparam int AW    = HISTORY_ADDR_BITS;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = (AW + 1 > 16) ? AW + 1 : 16;
  localparam int PACK  = (BYTES_PER_RESULT < 1) ? 1 :
                         (BYTES_PER_RESULT > 4) ? 4 : BYTES_PER_RESULT;
  localparam logic [2:0]  PACK_N = 3'(PACK);
  localparam logic [AW:0] FILL_MAX = (AW + 1)'(DEPTH);

  logic [7:0]    byte_q;
  phase_t        phase;
  logic [7:0]    flag_shift;
  logic [3:0]    bits_left;
  logic [15:0]   distance;
  logic [AW-1:0] wp;
  logic [AW:0]   fill;
  logic [AW-1:0] src;
  logic [7:0]    len_left;
  logic [7:0]    pack_buf [OUT_BYTES];
  logic [2:0]    buf_n;
  logic [7:0]    rdata;

  logic          we;
  logic [7:0]    wdata;
  logic [3:0]    bits_dec;
  logic [AW:0]   fill_inc;
  logic          load;
  logic [7:0]    res_byte [OUT_BYTES];
  logic [2:0]    res_count;
  status_t       res_status;
  logic          res_last;

  lfbd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (wp),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (src),
    .rdata (rdata)
  );

  assign we       = cmd.lit | cmd.wr;
  assign wdata    = cmd.lit ? byte_q : rdata;
  assign bits_dec = (bits_left != 4'd0) ? bits_left - 4'd1 : bits_left;
  assign fill_inc = (fill == FILL_MAX) ? fill : fill + 1'b1;

  always_comb begin
    sts.phase     = phase;
    sts.flag_bit  = flag_shift[7];
    sts.end_tok   = (distance == 16'd0) && (byte_q == 8'd0);
    sts.dist_bad  = (distance == 16'd0) || (CW'(distance) > CW'(fill));
    sts.len_zero  = (byte_q == 8'd0);
    sts.out_free  = !out_valid || !out_stall;
    sts.emit_due  = (buf_n + 3'd1 == PACK_N) || (len_left == 8'd1);
    sts.copy_last = (len_left == 8'd1);
  end

  // result being loaded into the output register
  always_comb begin
    load       = cmd.lit | cmd.end_mark | cmd.bad | (cmd.wr & sts.emit_due);
    res_count  = 3'd0;
    res_status = ST_DATA;
    res_last   = 1'b1;
    for (int j = 0; j < OUT_BYTES; j++) begin
      res_byte[j] = 8'd0;
    end
    if (cmd.lit) begin
      res_byte[0] = byte_q;
      res_count   = 3'd1;
    end else if (cmd.end_mark) begin
      res_status = ST_END;
    end else if (cmd.bad) begin
      res_status = ST_BAD;
    end else begin
      for (int j = 0; j < OUT_BYTES; j++) begin
        if (3'(j) < buf_n) begin
          res_byte[j] = pack_buf[j];
        end else if (3'(j) == buf_n) begin
          res_byte[j] = rdata;
        end
      end
      res_count = buf_n + 3'd1;
      res_last  = sts.copy_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FLAG;
      flag_shift <= 8'd0;
      bits_left  <= 4'd0;
      distance   <= 16'd0;
      wp         <= '0;
      fill       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.flag) begin
        flag_shift <= byte_q;
        bits_left  <= FLAG_ITEMS;
        phase      <= PH_ITEM;
      end
      if (cmd.lit) begin
        flag_shift <= {flag_shift[6:0], 1'b0};
        bits_left  <= bits_dec;
        phase      <= (bits_dec == 4'd0) ? PH_FLAG : PH_ITEM;
      end
      if (cmd.dlow) begin
        flag_shift     <= {flag_shift[6:0], 1'b0};
        bits_left      <= bits_dec;
        distance[7:0]  <= byte_q;
        phase          <= PH_DHIGH;
      end
      if (cmd.dhigh) begin
        distance[15:8] <= byte_q;
        phase          <= PH_LEN;
      end
      if (cmd.skip || (cmd.wr && sts.copy_last)) begin
        phase <= (bits_left == 4'd0) ? PH_FLAG : PH_ITEM;
      end
      if (we) begin
        wp   <= wp + 1'b1;
        fill <= fill_inc;
      end
      if (cmd.end_mark) begin
        fill       <= '0;
        phase      <= PH_FLAG;
        bits_left  <= 4'd0;
        flag_shift <= 8'd0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      byte_q <= in_byte;
    end
    if (cmd.copy_start) begin
      src      <= wp - AW'(distance);
      len_left <= byte_q;
      buf_n    <= 3'd0;
    end
    if (cmd.wr) begin
      src      <= src + 1'b1;
      len_left <= len_left - 8'd1;
      if (sts.emit_due) begin
        buf_n <= 3'd0;
      end else begin
        pack_buf[buf_n[1:0]] <= rdata;
        buf_n                <= buf_n + 3'd1;
      end
    end
    if (load) begin
      out_byte0  <= res_byte[0];
      out_byte1  <= res_byte[1];
      out_byte2  <= res_byte[2];
      out_byte3  <= res_byte[3];
      byte_count <= res_count;
      status     <= res_status;
      last       <= res_last;
    end
  end

endmodule

// ===== src/lfbd_ctrl.sv =====
module lfbd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  lfbd_pkg::sts_t sts,
  output lfbd_pkg::cmd_t cmd
);
  import lfbd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_READ   = 5'b00100,
    S_WRITE  = 5'b01000,
    S_HALT   = 5'b10000
  } state_t;

  state_t state, state_next;

  // halted: inputs are still taken but dropped
  assign in_stall = !((state == S_IDLE) || (state == S_HALT));

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.phase)
          PH_FLAG: begin
            cmd.flag   = 1'b1;
            state_next = S_IDLE;
          end
          PH_ITEM: begin
            if (sts.flag_bit) begin
              cmd.dlow   = 1'b1;
              state_next = S_IDLE;
            end else if (sts.out_free) begin
              cmd.lit    = 1'b1;
              state_next = S_IDLE;
            end
          end
          PH_DHIGH: begin
            cmd.dhigh  = 1'b1;
            state_next = S_IDLE;
          end
          PH_LEN: begin
            if (sts.end_tok) begin
              if (sts.out_free) begin
                cmd.end_mark = 1'b1;
                state_next   = S_IDLE;
              end
            end else if (sts.dist_bad) begin
              if (sts.out_free) begin
                cmd.bad    = 1'b1;
                state_next = S_HALT;
              end
            end else if (sts.len_zero) begin
              cmd.skip   = 1'b1;
              state_next = S_IDLE;
            end else begin
              cmd.copy_start = 1'b1;
              state_next     = S_READ;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        // read data holds while a packed result waits for the output register
        if (!sts.emit_due || sts.out_free) begin
          cmd.wr     = 1'b1;
          state_next = sts.copy_last ? S_IDLE : S_READ;
        end
      end
      S_HALT: state_next = S_HALT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/lfbd_checker.sv =====
module lfbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte0,
  input logic [7:0] out_byte1,
  input logic [7:0] out_byte2,
  input logic [7:0] out_byte3,
  input logic [2:0] byte_count,
  input logic [1:0] status,
  input logic       last
);
  import lfbd_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_count) && $stable(status)
      && $stable(last) && $stable(out_byte0) && $stable(out_byte3))
    else $error("stalled result changed");

  // marker and error results carry no bytes and close the item
  a_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_END || status == ST_BAD) |-> byte_count == 3'd0 && last)
    else $error("marker result with bytes or not last");

  // data results carry one to four bytes
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DATA |-> byte_count != 3'd0 && byte_count <= 3'd4)
    else $error("data result with bad byte count");

  // unused byte positions read as zero
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count > 3'd0 || out_byte0 == 8'd0)
      && (byte_count > 3'd1 || out_byte1 == 8'd0)
      && (byte_count > 3'd2 || out_byte2 == 8'd0)
      && (byte_count > 3'd3 || out_byte3 == 8'd0))
    else $error("unused byte position not zero");

endmodule

bind lzss_flag_byte_decoder lfbd_checker u_lfbd_checker (.*);

// ===== sim/lzss_flag_byte_decoder_test.sv =====
module lzss_flag_byte_decoder_test;
  import lfbd_pkg::*;

  localparam int HAB = 16;
  localparam int BPR = 4;
  localparam int PACK = (BPR < 1) ? 1 : ((BPR > 4) ? 4 : BPR);
  localparam int HIST_DEPTH = 1 << HAB;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 420;
  localparam int SETTLE_CYCLES = 600;

  typedef struct packed {
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] d3;
    logic [2:0] count;
    status_t    st;
    logic       last;
  } result_t;

  typedef struct {
    logic [7:0] val;
    bit         typed;
    result_t    want;
  } stim_row_t;

  typedef enum {GEN_MIX, GEN_BULK, GEN_FAR} gen_mode_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;
  logic [2:0] byte_count;
  logic [1:0] status;
  logic       last;

  // decoder state as the block should hold it
  logic [7:0]     hist_mem [HIST_DEPTH];
  logic [HAB-1:0] wr_ptr = '0;
  logic [HAB:0]   fill_cnt = '0;
  phase_t         parse_ph = PH_FLAG;
  logic [7:0]     flag_reg = '0;
  logic [3:0]     flags_left = '0;
  logic [15:0]    dist_reg = '0;
  bit             stopped = 1'b0;

  result_t   due_results[$];
  stim_row_t script[$];
  bit        quiet = 1'b0;
  int        n_items = 0;
  int        n_results = 0;
  int        n_out_bytes = 0;
  int        n_ends = 0;
  int        n_errors = 0;
  int        idle_cycles = 0;

  lzss_flag_byte_decoder #(
    .HISTORY_ADDR_BITS(HAB),
    .BYTES_PER_RESULT (BPR)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte0 (out_byte0),
    .out_byte1 (out_byte1),
    .out_byte2 (out_byte2),
    .out_byte3 (out_byte3),
    .byte_count(byte_count),
    .status    (status),
    .last      (last)
  );

  always #5 clk = ~clk;

  function automatic result_t res(input logic [7:0] b, input logic [2:0] n, input status_t st);
    res = '{b, 8'h00, 8'h00, 8'h00, n, st, 1'b1};
  endfunction

  function automatic stim_row_t row(input logic [7:0] v, input bit typed = 1'b0,
                                    input result_t want = '0);
    stim_row_t s;
    s.val = v;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic void add_row(input logic [7:0] v, input bit typed = 1'b0,
                                  input result_t want = '0);
    script = {script, row(v, typed, want)};
  endfunction

  function automatic void store_byte(input logic [7:0] v);
    hist_mem[wr_ptr] = v;
    wr_ptr++;
    if (fill_cnt < HIST_DEPTH) fill_cnt++;
  endfunction

  // works out the results one stream byte gives and advances the state
  function automatic void decode_byte(input logic [7:0] b, ref result_t made[$]);
    logic           top;
    logic [HAB-1:0] src;
    logic [7:0]     c;
    logic [7:0]     grp [4];
    int             n;
    int             len;
    int             i;
    result_t        r;
    made = {};
    if (stopped) return;
    case (parse_ph)
      PH_FLAG: begin
        flag_reg = b;
        flags_left = FLAG_ITEMS;
        parse_ph = PH_ITEM;
      end
      PH_ITEM: begin
        top = flag_reg[7];
        flag_reg = flag_reg << 1;
        if (flags_left != 0) flags_left--;
        if (!top) begin
          store_byte(b);
          made = {made, res(b, 3'd1, ST_DATA)};
          parse_ph = (flags_left == 0) ? PH_FLAG : PH_ITEM;
        end else begin
          dist_reg = {8'h00, b};
          parse_ph = PH_DHIGH;
        end
      end
      PH_DHIGH: begin
        dist_reg[15:8] = b;
        parse_ph = PH_LEN;
      end
      default: begin
        len = int'(b);
        if (dist_reg == 0 && len == 0) begin
          fill_cnt = '0;
          parse_ph = PH_FLAG;
          flags_left = '0;
          flag_reg = '0;
          made = {made, res(8'h00, 3'd0, ST_END)};
        end else if (dist_reg == 0 || dist_reg > fill_cnt) begin
          stopped = 1'b1;
          made = {made, res(8'h00, 3'd0, ST_BAD)};
        end else begin
          src = wr_ptr - dist_reg[HAB-1:0];
          n = 0;
          grp = '{default: 8'h00};
          // byte by byte, so an overlapping copy reads what it has just written
          for (i = 0; i < len; i++) begin
            c = hist_mem[src];
            src++;
            store_byte(c);
            grp[n] = c;
            n++;
            if (n == PACK || i + 1 == len) begin
              r.d0 = grp[0];
              r.d1 = grp[1];
              r.d2 = grp[2];
              r.d3 = grp[3];
              r.count = 3'(n);
              r.st = ST_DATA;
              r.last = (i + 1 == len);
              made = {made, r};
              n = 0;
              grp = '{default: 8'h00};
            end
          end
          parse_ph = (flags_left == 0) ? PH_FLAG : PH_ITEM;
        end
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input result_t want = '0);
    int      gap;
    result_t made[$];
    gap = quiet ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_byte = b;
    do @(posedge clk); while (in_stall);
    if (!stopped) n_items++;
    decode_byte(b, made);
    if (typed) due_results = {due_results, want};
    else foreach (made[k]) due_results = {due_results, made[k]};
  endtask

  task automatic walk_script();
    foreach (script[k]) send_byte(script[k].val, script[k].typed, script[k].want);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // one flag byte and the items it announces, always well formed
  task automatic send_group(input gen_mode_t mode);
    logic [7:0]  flag_v;
    logic [15:0] d;
    logic [7:0]  len_v;
    int          maxd;
    int          k;
    quiet = ($urandom_range(0, 5) == 0);
    case (mode)
      GEN_BULK: flag_v = 8'h7F;
      default: begin
        case ($urandom_range(0, 7))
          0: flag_v = 8'h00;
          1: flag_v = 8'hFF;
          default: flag_v = 8'($urandom_range(0, 255));
        endcase
      end
    endcase
    send_byte(flag_v);
    for (k = 7; k >= 0 && parse_ph != PH_FLAG; k--) begin
      if (!flag_v[k]) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (fill_cnt == 0 || (mode == GEN_MIX && $urandom_range(0, 24) == 0)) begin
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
      end else begin
        maxd = (fill_cnt > 65535) ? 65535 : int'(fill_cnt);
        case (mode)
          GEN_BULK: begin
            d = 16'($urandom_range(1, maxd));
            len_v = 8'hFF;
          end
          GEN_FAR: begin
            d = 16'(maxd - int'($urandom_range(0, 3)));
            len_v = 8'($urandom_range(1, 16));
          end
          default: begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3: d = 16'($urandom_range(1, (maxd < 4) ? maxd : 4));
              4: d = 16'(maxd);
              5: d = 16'd1;
              default: d = 16'($urandom_range(1, maxd));
            endcase
            case ($urandom_range(0, 15))
              0: len_v = 8'h00;
              1: len_v = 8'($urandom_range(13, 255));
              default: len_v = 8'($urandom_range(1, 12));
            endcase
          end
        endcase
        send_byte(d[7:0]);
        send_byte(d[15:8]);
        send_byte(len_v);
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t w;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      n_out_bytes += int'(byte_count);
      if (status == ST_END) n_ends++;
      if (due_results.size() == 0) begin
        $error("result with nothing expected: byte_count %0d status %0d", byte_count, status);
        n_errors++;
      end else begin
        w = due_results.pop_front();
        check_field("out_byte0", int'(w.d0), int'(out_byte0));
        check_field("out_byte1", int'(w.d1), int'(out_byte1));
        check_field("out_byte2", int'(w.d2), int'(out_byte2));
        check_field("out_byte3", int'(w.d3), int'(out_byte3));
        check_field("byte_count", int'(w.count), int'(byte_count));
        check_field("status", int'(w.st), int'(status));
        check_field("last", int'(w.last), int'(last));
      end
    end
  end

  // only counts while something is owed: an offered byte or a pending result
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (!in_valid && due_results.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results still due", idle_cycles,
               due_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : result_side
    int w;
    out_stall = 1'b0;
    forever begin
      w = quiet ? 0 : $urandom_range(0, 15);
      repeat (w) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : stream_side
    logic [15:0] d;
    logic [7:0]  v1;
    logic [7:0]  v2;
    logic [7:0]  len_v;
    int          base;
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // eight literals, then tokens: overlapping copy, copy from the fill edge,
    // zero length copy and an end marker part way through the flags
    add_row(8'h00);
    add_row(8'h00, 1'b1, res(8'h00, 3'd1, ST_DATA));
    add_row(8'hFF, 1'b1, res(8'hFF, 3'd1, ST_DATA));
    add_row(8'hA5, 1'b1, res(8'hA5, 3'd1, ST_DATA));
    add_row(8'h5A, 1'b1, res(8'h5A, 3'd1, ST_DATA));
    add_row(8'h01, 1'b1, res(8'h01, 3'd1, ST_DATA));
    add_row(8'h80, 1'b1, res(8'h80, 3'd1, ST_DATA));
    add_row(8'h7F, 1'b1, res(8'h7F, 3'd1, ST_DATA));
    add_row(8'hFE, 1'b1, res(8'hFE, 3'd1, ST_DATA));
    add_row(8'hFF);
    add_row(8'h01);
    add_row(8'h00);
    add_row(8'h09);
    add_row(8'h11);
    add_row(8'h00);
    add_row(8'hFF);
    add_row(8'h01);
    add_row(8'h00);
    add_row(8'h00);
    add_row(8'h00);
    add_row(8'h00);
    add_row(8'h00, 1'b1, res(8'h00, 3'd0, ST_END));
    walk_script();
    hold_until_drained();

    base = n_items;
    while (n_items < base + RANDOM_ITEMS) send_group(GEN_MIX);
    hold_until_drained();

    // long copies until the history is full and the write pointer has wrapped
    while (fill_cnt != HIST_DEPTH) send_group(GEN_BULK);
    repeat (2) send_group(GEN_FAR);
    hold_until_drained();

    // end marker, two literals, then a bad distance and bytes sent into the halt
    v1 = 8'($urandom_range(0, 255));
    v2 = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 0) begin
      d = 16'($urandom_range(3, 65535));
      len_v = 8'($urandom_range(0, 255));
    end else begin
      d = 16'h0000;
      len_v = 8'($urandom_range(1, 255));
    end
    script = {};
    add_row(8'h80);
    add_row(8'h00);
    add_row(8'h00);
    add_row(8'h00, 1'b1, res(8'h00, 3'd0, ST_END));
    add_row(8'h20);
    add_row(v1, 1'b1, res(v1, 3'd1, ST_DATA));
    add_row(v2, 1'b1, res(v2, 3'd1, ST_DATA));
    add_row(d[7:0]);
    add_row(d[15:8]);
    add_row(len_v, 1'b1, res(8'h00, 3'd0, ST_BAD));
    repeat (4) add_row(8'($urandom_range(0, 255)));
    quiet = 1'b0;
    walk_script();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d stream bytes gave %0d results carrying %0d bytes, %0d end markers",
             n_items, n_results, n_out_bytes, n_ends);
    $display("history filled and wrapped, far copies done, stream halted on a bad distance");
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
